// ----- src/mrs_pkg.sv -----
// Shared types, constants and functions of the Modbus RTU frame scanner.
package mrs_pkg;

	localparam int unsigned RTU_MIN_BYTES = 4;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [1:0] CFG_OWN_UNIT   = 2'd0;
	localparam logic [1:0] CFG_ACCEPT_ANY = 2'd1;
	localparam logic [1:0] CFG_DECODE_REQ = 2'd2;

	typedef enum logic [1:0] {
		EV_ACCEPT = 2'd0,
		EV_REJECT = 2'd1,
		EV_DROP   = 2'd2
	} event_t;

	typedef enum logic [2:0] {
		LK_FIXED   = 3'b001,
		LK_COUNT   = 3'b010,
		LK_UNKNOWN = 3'b100
	} len_kind_t;

	typedef struct packed {
		len_kind_t   kind;
		logic [8:0]  len;
		logic [2:0]  off;
	} len_info_t;

	typedef struct packed {
		event_t      ev;
		logic [7:0]  unit;
		logic [7:0]  fc;
		logic [8:0]  len;
		logic [8:0]  crc_drops;
		logic [8:0]  unk_drops;
		logic        last;
	} res_t;

	function automatic len_info_t classify(input logic [7:0] fc, input logic dec_req);
		len_info_t r;
		r.kind = LK_UNKNOWN;
		r.len  = 9'd0;
		r.off  = 3'd0;
		if (fc[7]) begin
			r.kind = LK_FIXED;
			r.len  = 9'd5;
		end else if (dec_req) begin
			if (fc >= 8'd1 && fc <= 8'd6) begin
				r.kind = LK_FIXED;
				r.len  = 9'd8;
			end else if (fc == 8'd15 || fc == 8'd16) begin
				r.kind = LK_COUNT;
				r.len  = 9'd9;
				r.off  = 3'd6;
			end
		end else begin
			if (fc == 8'd5 || fc == 8'd6 || fc == 8'd15 || fc == 8'd16) begin
				r.kind = LK_FIXED;
				r.len  = 9'd8;
			end else if (fc >= 8'd1 && fc <= 8'd4) begin
				r.kind = LK_COUNT;
				r.len  = 9'd5;
				r.off  = 3'd2;
			end
		end
		return r;
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- src/mrs_front.sv -----
// Input side: accepts received bytes into a short queue toward the scanner.
module mrs_front (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       q_valid,
	output logic [7:0] q_byte,
	input  logic       q_pop
);
	import mrs_pkg::*;

	logic [7:0] slot_q [2];
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_byte   = slot_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop && q_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_valid) begin
			slot_q[0] <= slot_q[1];
			if (push && cnt_q == 2'd1) slot_q[0] <= rx_byte;
			if (push && cnt_q == 2'd2) slot_q[1] <= rx_byte;
		end else if (push) begin
			if (cnt_q == 2'd0) slot_q[0] <= rx_byte;
			else slot_q[1] <= rx_byte;
		end
	end

endmodule

// ----- src/mrs_back.sv -----
// Scanner: byte buffer, frame length decode, CRC check and result sequencing.
module mrs_back #(
	parameter int unsigned BUF_BYTES = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  logic [7:0]    q_byte,
	output logic          q_pop,
	input  logic [7:0]    own_unit,
	input  logic          accept_any_unit,
	input  logic          decode_requests,
	output mrs_pkg::res_t res,
	output logic          res_valid,
	input  logic          res_ready
);
	import mrs_pkg::*;

	localparam int unsigned AW = $clog2(BUF_BYTES);
	localparam int unsigned FW = AW + 1;
	localparam logic [FW-1:0] BUF_N = FW'(BUF_BYTES);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_CHK  = 9'b000000010,
		S_FC   = 9'b000000100,
		S_OFF  = 9'b000001000,
		S_LEN  = 9'b000010000,
		S_CRC  = 9'b000100000,
		S_RX0  = 9'b001000000,
		S_RX1  = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	logic [7:0]    mem [BUF_BYTES];
	logic [7:0]    rd_data_q;
	logic [AW-1:0] rd_addr;
	logic          mem_we;
	logic [AW-1:0] mem_wa;

	state_t        state_q;
	logic [AW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [7:0]    fc_q, unit_q, rxlo_q;
	logic [8:0]    len_q, idx_q;
	logic [15:0]   crc_q;
	logic [8:0]    pend_crc_q, pend_unk_q;
	res_t          held_q, new_q, out_q;
	logic          held_v_q, out_v_q, emit_q;
	len_info_t     info;
	logic          out_free, pend_any, out_load;
	logic [FW-1:0] len_ext;

	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [FW-1:0] ofs);
		logic [FW-1:0] s;
		s = {1'b0, base} + ofs;
		if (s >= BUF_N) s = s - BUF_N;
		return s[AW-1:0];
	endfunction

	assign info     = classify(rd_data_q, decode_requests);
	assign out_free = !out_v_q || res_ready;
	assign pend_any = (pend_crc_q != 9'd0) || (pend_unk_q != 9'd0);
	assign out_load = ((state_q == S_CHK) && emit_q && held_v_q && out_free) ||
		((state_q == S_FIN) && out_free && (held_v_q || pend_any));
	assign len_ext  = FW'(len_q);
	assign res      = out_q;
	assign res_valid = out_v_q;
	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign mem_we   = q_pop;
	assign mem_wa   = (fill_q == BUF_N) ? head_q : wrap(head_q, fill_q);

	always_comb begin
		case (state_q)
			S_CHK:        rd_addr = wrap(head_q, FW'(1));
			S_FC:         rd_addr = wrap(head_q, FW'(info.off));
			S_CRC, S_RX0: rd_addr = wrap(head_q, FW'(idx_q) + FW'(1));
			default:      rd_addr = head_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= q_byte;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			fill_q     <= '0;
			pend_crc_q <= 9'd0;
			pend_unk_q <= 9'd0;
			held_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			emit_q     <= 1'b0;
		end else begin
			if (out_load) out_v_q <= 1'b1;
			else if (res_ready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (fill_q == BUF_N) head_q <= wrap(head_q, FW'(1));
						else fill_q <= fill_q + FW'(1);
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (emit_q) begin
						if (!held_v_q || out_free) begin
							if (held_v_q) out_q <= held_q;
							held_q     <= new_q;
							held_v_q   <= 1'b1;
							pend_crc_q <= 9'd0;
							pend_unk_q <= 9'd0;
							head_q     <= wrap(head_q, len_ext);
							fill_q     <= fill_q - len_ext;
							emit_q     <= 1'b0;
						end
					end else if (fill_q < FW'(RTU_MIN_BYTES)) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_FC;
					end
				end
				S_FC: begin
					fc_q <= rd_data_q;
					len_q <= info.len;
					case (info.kind)
						LK_FIXED: state_q <= S_LEN;
						LK_COUNT: state_q <= (fill_q <= FW'(info.off)) ? S_FIN : S_OFF;
						default: begin
							pend_unk_q <= pend_unk_q + 9'd1;
							head_q     <= wrap(head_q, FW'(1));
							fill_q     <= fill_q - FW'(1);
							state_q    <= S_CHK;
						end
					endcase
				end
				S_OFF: begin
					len_q   <= len_q + {1'b0, rd_data_q};
					state_q <= S_LEN;
				end
				S_LEN: begin
					crc_q <= CRC_INIT;
					idx_q <= 9'd0;
					state_q <= (fill_q < len_ext) ? S_FIN : S_CRC;
				end
				S_CRC: begin
					if (idx_q == 9'd0) unit_q <= rd_data_q;
					crc_q <= crc_byte(crc_q, rd_data_q);
					idx_q <= idx_q + 9'd1;
					if (idx_q + 9'd1 == len_q - 9'd2) state_q <= S_RX0;
				end
				S_RX0: begin
					rxlo_q  <= rd_data_q;
					state_q <= S_RX1;
				end
				S_RX1: begin
					if ({rd_data_q, rxlo_q} != crc_q) begin
						pend_crc_q <= pend_crc_q + 9'd1;
						head_q     <= wrap(head_q, FW'(1));
						fill_q     <= fill_q - FW'(1);
					end else begin
						new_q.ev <= (!accept_any_unit && decode_requests &&
							unit_q != own_unit && unit_q != 8'd0) ? EV_REJECT : EV_ACCEPT;
						new_q.unit      <= unit_q;
						new_q.fc        <= fc_q;
						new_q.len       <= len_q;
						new_q.crc_drops <= pend_crc_q;
						new_q.unk_drops <= pend_unk_q;
						new_q.last      <= 1'b0;
						emit_q          <= 1'b1;
					end
					state_q <= S_CHK;
				end
				S_FIN: begin
					if (held_v_q) begin
						if (out_free) begin
							out_q.ev        <= held_q.ev;
							out_q.unit      <= held_q.unit;
							out_q.fc        <= held_q.fc;
							out_q.len       <= held_q.len;
							out_q.crc_drops <= held_q.crc_drops;
							out_q.unk_drops <= held_q.unk_drops;
							out_q.last      <= !pend_any;
							held_v_q        <= 1'b0;
							if (!pend_any) state_q <= S_IDLE;
						end
					end else if (!pend_any) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q.ev        <= EV_DROP;
						out_q.unit      <= 8'd0;
						out_q.fc        <= 8'd0;
						out_q.len       <= 9'd0;
						out_q.crc_drops <= pend_crc_q;
						out_q.unk_drops <= pend_unk_q;
						out_q.last      <= 1'b1;
						pend_crc_q      <= 9'd0;
						pend_unk_q      <= 9'd0;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- src/modbus_rtu_frame_scanner.sv -----
// Top level of the Modbus RTU frame scanner.
// Bytes enter on in_valid/in_ready with rx_byte, one beat per byte, into a
// two-entry queue; the scanner appends each byte to a circular buffer and
// scans from the buffer head until more bytes are needed.
// Each scan result leaves on out_valid/out_ready: a frame accepted, a frame
// rejected by address, or a report of dropped bytes; last marks the final
// result caused by one byte.
// The scanner takes a queued byte only while it is idle and finishes its
// scan before it takes the next; the input queue holds bytes meanwhile.
// With fewer than four bytes held the scan ends without a length decode. A
// byte that completes a good frame has its result registered in the
// scanner; byte-count layouts add a read of the count byte. Each CRC failure
// drops one head byte and rescans from the next. The serial CRC pass over
// the single buffer read port sets the throughput.
// The user writes configuration through cfg_we/cfg_index/cfg_data only while
// idle; the block does not enforce it. Reset empties the buffer and clears
// drop counts; its contents need no clearing. When the receiver stalls, one
// result waits in the output register, two in the scanner; the queue fills.
module modbus_rtu_frame_scanner #(
	parameter int unsigned BUF_BYTES = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_res,
	output logic [7:0] unit_seen,
	output logic [7:0] function_code,
	output logic [8:0] frame_length,
	output logic [8:0] crc_drops,
	output logic [8:0] unknown_drops,
	output logic       last,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import mrs_pkg::*;

	logic       q_valid, q_pop;
	logic [7:0] q_byte;
	logic [7:0] own_unit_q;
	logic       accept_any_q, decode_req_q;
	res_t       res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_unit_q   <= 8'd1;
			accept_any_q <= 1'b0;
			decode_req_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OWN_UNIT:   own_unit_q   <= cfg_data;
				CFG_ACCEPT_ANY: accept_any_q <= cfg_data[0];
				CFG_DECODE_REQ: decode_req_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	mrs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.q_valid  (q_valid),
		.q_byte   (q_byte),
		.q_pop    (q_pop)
	);

	mrs_back #(.BUF_BYTES(BUF_BYTES)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_byte          (q_byte),
		.q_pop           (q_pop),
		.own_unit        (own_unit_q),
		.accept_any_unit (accept_any_q),
		.decode_requests (decode_req_q),
		.res             (res),
		.res_valid       (out_valid),
		.res_ready       (out_ready)
	);

	assign event_res     = res.ev;
	assign unit_seen     = res.unit;
	assign function_code = res.fc;
	assign frame_length  = res.len;
	assign crc_drops     = res.crc_drops;
	assign unknown_drops = res.unk_drops;
	assign last          = res.last;

endmodule

// ----- src/mrs_checker.sv -----
// Port-level checks of the frame scanner and their binding to the top level.
module mrs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] event_res,
	input logic [7:0] unit_seen,
	input logic [8:0] frame_length,
	input logic [8:0] crc_drops,
	input logic [8:0] unknown_drops,
	input logic       last
);
	import mrs_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped under stall");

	a_drop_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_DROP |->
			unit_seen == 8'd0 && frame_length == 9'd0 && last &&
			(crc_drops != 9'd0 || unknown_drops != 9'd0))
		else $error("malformed drop report");

	a_frame_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_DROP |-> frame_length >= 9'd5)
		else $error("frame shorter than minimum");

	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_res != 2'd3)
		else $error("invalid event code");

endmodule

bind modbus_rtu_frame_scanner mrs_checker u_mrs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.event_res     (event_res),
	.unit_seen     (unit_seen),
	.frame_length  (frame_length),
	.crc_drops     (crc_drops),
	.unknown_drops (unknown_drops),
	.last          (last)
);
